// File: rtl/l3s_pkg.sv
// Shared types and constants for the 3D line stepper.
// No dependencies; every other file in rtl uses this package.
`timescale 1ns / 1ps

package l3s_pkg;

   localparam int COORD_BITS = 6;
   // Error terms swing between about -2*dm and +2*dm; three extra bits cover it.
   localparam int ERR_BITS   = COORD_BITS + 3;

   typedef logic [COORD_BITS-1:0] coord_type;
   typedef logic [ERR_BITS-1:0]   err_type;

   typedef enum logic [1:0] {
      AXIS_X,
      AXIS_Y,
      AXIS_Z
   } axis_type;

   typedef enum logic {
      ST_IDLE,
      ST_STEP
   } l3s_state_type;

   // Controller to datapath.
   typedef struct packed {
      logic load;   // capture a new segment from the request ports
      logic step;   // advance one point into the output register
   } l3s_cmd_type;

   // Datapath to controller.
   typedef struct packed {
      logic remaining_zero;   // all points of the segment are issued
      logic out_free;         // output register empty or being taken
   } l3s_status_type;

endpackage

// File: rtl/l3s_ctrl.sv
// Controller state machine for the 3D line stepper.
// Depends on l3s_pkg; drives load and step commands into l3s_dp.
`timescale 1ns / 1ps

module l3s_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  l3s_pkg::l3s_status_type status,
   output l3s_pkg::l3s_cmd_type    cmd
);

   l3s_pkg::l3s_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= l3s_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         l3s_pkg::ST_IDLE: begin
            if (req_valid) state_in = l3s_pkg::ST_STEP;
         end
         l3s_pkg::ST_STEP: begin
            if (status.remaining_zero) state_in = l3s_pkg::ST_IDLE;
         end
         default: state_in = l3s_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      req_ready = 1'b0;
      cmd.load  = 1'b0;
      cmd.step  = 1'b0;
      case (state_ff)
         l3s_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            cmd.load  = req_valid;
         end
         l3s_pkg::ST_STEP: begin
            cmd.step = !status.remaining_zero && status.out_free;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

endmodule

// File: rtl/l3s_dp.sv
// Datapath for the 3D line stepper: segment setup, stepping registers, output register.
// Depends on l3s_pkg; commanded by l3s_ctrl.
`timescale 1ns / 1ps

module l3s_dp (
   input  logic                    clock,
   input  logic                    reset,
   input  l3s_pkg::l3s_cmd_type    cmd,
   output l3s_pkg::l3s_status_type status,
   input  l3s_pkg::coord_type      req_start_x,
   input  l3s_pkg::coord_type      req_start_y,
   input  l3s_pkg::coord_type      req_start_z,
   input  l3s_pkg::coord_type      req_end_x,
   input  l3s_pkg::coord_type      req_end_y,
   input  l3s_pkg::coord_type      req_end_z,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output l3s_pkg::coord_type      rsp_point_x,
   output l3s_pkg::coord_type      rsp_point_y,
   output l3s_pkg::coord_type      rsp_point_z,
   output logic                    rsp_last_point
);

   // Segment state
   l3s_pkg::coord_type cur_x_ff, cur_y_ff, cur_z_ff;
   l3s_pkg::coord_type cur_x_in, cur_y_in, cur_z_in;
   l3s_pkg::err_type   err_first_ff, err_second_ff, err_first_in, err_second_in;
   l3s_pkg::coord_type dm_ff, d1_ff, d2_ff;
   l3s_pkg::coord_type remaining_ff, remaining_in;
   l3s_pkg::axis_type  major_ff;
   logic [2:0]         signs_ff;

   // Output register
   l3s_pkg::coord_type out_x_ff, out_y_ff, out_z_ff;
   logic               out_last_ff;
   logic               out_valid_ff, out_valid_in;

   // Setup terms
   l3s_pkg::coord_type dx, dy, dz, dm_sel, d1_sel, d2_sel;
   l3s_pkg::axis_type  major_sel;
   logic               ux, uy, uz;
   l3s_pkg::err_type   err_first_init, err_second_init;

   // Step terms
   logic               a1, a2, mx, my, mz;
   l3s_pkg::err_type   twice_dm;

   always_comb begin
      ux = req_end_x > req_start_x;
      uy = req_end_y > req_start_y;
      uz = req_end_z > req_start_z;
      dx = ux ? req_end_x - req_start_x : req_start_x - req_end_x;
      dy = uy ? req_end_y - req_start_y : req_start_y - req_end_y;
      dz = uz ? req_end_z - req_start_z : req_start_z - req_end_z;
      // Ties go to X, then Y.
      if (dx >= dy && dx >= dz) begin
         major_sel = l3s_pkg::AXIS_X;
         dm_sel = dx;
         d1_sel = dy;
         d2_sel = dz;
      end else if (dy >= dz) begin
         major_sel = l3s_pkg::AXIS_Y;
         dm_sel = dy;
         d1_sel = dx;
         d2_sel = dz;
      end else begin
         major_sel = l3s_pkg::AXIS_Z;
         dm_sel = dz;
         d1_sel = dy;
         d2_sel = dx;
      end
      err_first_init  = {2'b00, d1_sel, 1'b0} - {3'b000, dm_sel};
      err_second_init = {2'b00, d2_sel, 1'b0} - {3'b000, dm_sel};
   end

   always_comb begin
      a1 = !err_first_ff[l3s_pkg::ERR_BITS-1];
      a2 = !err_second_ff[l3s_pkg::ERR_BITS-1];
      twice_dm = {2'b00, dm_ff, 1'b0};
      err_first_in  = err_first_ff - (a1 ? twice_dm : '0) + {2'b00, d1_ff, 1'b0};
      err_second_in = err_second_ff - (a2 ? twice_dm : '0) + {2'b00, d2_ff, 1'b0};
      case (major_ff)
         l3s_pkg::AXIS_X: begin
            mx = 1'b1;
            my = a1;
            mz = a2;
         end
         l3s_pkg::AXIS_Y: begin
            mx = a1;
            my = 1'b1;
            mz = a2;
         end
         l3s_pkg::AXIS_Z: begin
            mx = a2;
            my = a1;
            mz = 1'b1;
         end
         default: begin
            mx = 1'b0;
            my = 1'b0;
            mz = 1'b0;
         end
      endcase
      cur_x_in = cur_x_ff;
      cur_y_in = cur_y_ff;
      cur_z_in = cur_z_ff;
      if (mx) cur_x_in = signs_ff[0] ? cur_x_ff + l3s_pkg::coord_type'(1)
                                     : cur_x_ff - l3s_pkg::coord_type'(1);
      if (my) cur_y_in = signs_ff[1] ? cur_y_ff + l3s_pkg::coord_type'(1)
                                     : cur_y_ff - l3s_pkg::coord_type'(1);
      if (mz) cur_z_in = signs_ff[2] ? cur_z_ff + l3s_pkg::coord_type'(1)
                                     : cur_z_ff - l3s_pkg::coord_type'(1);
      remaining_in = remaining_ff - l3s_pkg::coord_type'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         remaining_ff <= '0;
      end else if (cmd.load) begin
         remaining_ff <= dm_sel;
      end else if (cmd.step) begin
         remaining_ff <= remaining_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         cur_x_ff      <= req_start_x;
         cur_y_ff      <= req_start_y;
         cur_z_ff      <= req_start_z;
         err_first_ff  <= err_first_init;
         err_second_ff <= err_second_init;
         dm_ff         <= dm_sel;
         d1_ff         <= d1_sel;
         d2_ff         <= d2_sel;
         major_ff      <= major_sel;
         signs_ff      <= {uz, uy, ux};
      end else if (cmd.step) begin
         cur_x_ff      <= cur_x_in;
         cur_y_ff      <= cur_y_in;
         cur_z_ff      <= cur_z_in;
         err_first_ff  <= err_first_in;
         err_second_ff <= err_second_in;
      end
   end

   // Hold the point until taken; a new step only lands when the register is free.
   always_comb begin
      status.out_free       = !out_valid_ff || rsp_ready;
      status.remaining_zero = (remaining_ff == '0);
      out_valid_in = cmd.step || (out_valid_ff && !rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.step) begin
         out_x_ff    <= cur_x_in;
         out_y_ff    <= cur_y_in;
         out_z_ff    <= cur_z_in;
         out_last_ff <= (remaining_ff == l3s_pkg::coord_type'(1));
      end
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_point_x    = out_x_ff;
   assign rsp_point_y    = out_y_ff;
   assign rsp_point_z    = out_z_ff;
   assign rsp_last_point = out_last_ff;

endmodule

// File: rtl/line_3d_stepper_core.sv
// After a segment is accepted, its first point goes through the segment registers and the output register.
// Throughput: one point per cycle while the output is taken; a segment with major delta
// dm occupies the block through setup, a step for each of the dm points, and a retire
// step before the controller returns to idle.
// The rate is set by the single stepping unit, which issues one point per cycle while the output register is free.
// Reset (synchronous, active high) returns the controller to idle and empties the output.
`timescale 1ns / 1ps

module line_3d_stepper_core (
   input  logic               clock,
   input  logic               reset,
   // Segment request channel
   input  logic               req_valid,
   output logic               req_ready,
   input  l3s_pkg::coord_type req_start_x,
   input  l3s_pkg::coord_type req_start_y,
   input  l3s_pkg::coord_type req_start_z,
   input  l3s_pkg::coord_type req_end_x,
   input  l3s_pkg::coord_type req_end_y,
   input  l3s_pkg::coord_type req_end_z,
   // Point result channel
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output l3s_pkg::coord_type rsp_point_x,
   output l3s_pkg::coord_type rsp_point_y,
   output l3s_pkg::coord_type rsp_point_z,
   output logic               rsp_last_point
);

   // Commands run one way, status the other; no other wires join the two halves.
   l3s_pkg::l3s_cmd_type    cmd;
   l3s_pkg::l3s_status_type status;

   // Controller: accept a segment when idle, then step until every point is issued.
   l3s_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   // Datapath: set up deltas and error terms, advance the point, hold the output item.
   // The output register lets a new segment load while the last point still waits.
   l3s_dp u_dp (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .status         (status),
      .req_start_x    (req_start_x),
      .req_start_y    (req_start_y),
      .req_start_z    (req_start_z),
      .req_end_x      (req_end_x),
      .req_end_y      (req_end_y),
      .req_end_z      (req_end_z),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_point_x    (rsp_point_x),
      .rsp_point_y    (rsp_point_y),
      .rsp_point_z    (rsp_point_z),
      .rsp_last_point (rsp_last_point)
   );

endmodule

// File: rtl/l3s_checker.sv
// Port-level assertions for the 3D line stepper, bound to the top level.
// Depends on l3s_pkg and line_3d_stepper_core.
`timescale 1ns / 1ps

module l3s_checker (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_ready,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input l3s_pkg::coord_type rsp_point_x,
   input l3s_pkg::coord_type rsp_point_y,
   input l3s_pkg::coord_type rsp_point_z,
   input logic               rsp_last_point
);

   // A stalled item holds.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_point_x)
         && $stable(rsp_point_y) && $stable(rsp_point_z) && $stable(rsp_last_point))
      else $error("result item changed while stalled");

   // An accepted segment always keeps the block busy for the next cycle.
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request ready right after accepting a segment");

   // No new segment while the current one still has points to issue.
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last_point |-> !req_ready)
      else $error("request ready in the middle of a segment");

   // A presented item carries no unknown bits.
   a_rsp_known: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !$isunknown({rsp_point_x, rsp_point_y, rsp_point_z, rsp_last_point}))
      else $error("result item has unknown bits");

endmodule

bind line_3d_stepper_core l3s_checker u_l3s_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_valid),
   .req_ready      (req_ready),
   .rsp_valid      (rsp_valid),
   .rsp_ready      (rsp_ready),
   .rsp_point_x    (rsp_point_x),
   .rsp_point_y    (rsp_point_y),
   .rsp_point_z    (rsp_point_z),
   .rsp_last_point (rsp_last_point)
);
